@@ rtl/assert_macros.svh @@
// Assertion macros shared by the rotation address generator modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent property checked on every rising edge outside reset.
`define IRR_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Condition that must never be seen outside reset.
`define IRR_ASSERT_NEVER(lbl, clk, rst, expr, msg) \
  `IRR_ASSERT(lbl, clk, rst, !(expr), msg)

`endif

@@ rtl/irr_pkg.sv @@
// Shared types, constants and helpers of the right-angle rotation block.
package irr_pkg;

  localparam int SIZE_W      = 13;
  localparam int CH_W        = 3;
  localparam int MODE_W      = 2;
  localparam int SAMPLE_W    = 8;
  localparam int INDEX_W     = 26;
  localparam int CFG_DATA_W  = 13;
  localparam int CFG_INDEX_W = 2;

  localparam int DEF_MAX_WIDTH    = 4096;
  localparam int DEF_MAX_HEIGHT   = 4096;
  localparam int DEF_MAX_CHANNELS = 4;

  localparam int QUEUE_DEPTH = 4;

  localparam logic [SIZE_W-1:0] RESET_WIDTH    = SIZE_W'(1);
  localparam logic [SIZE_W-1:0] RESET_HEIGHT   = SIZE_W'(1);
  localparam logic [CH_W-1:0]   RESET_CHANNELS = CH_W'(3);

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_IMAGE_WIDTH   = 2'd0,
    REG_IMAGE_HEIGHT  = 2'd1,
    REG_CHANNEL_COUNT = 2'd2,
    REG_ROTATION_MODE = 2'd3
  } reg_index_t;

  typedef enum logic [MODE_W-1:0] {
    MODE_NONE   = 2'd0,
    MODE_ROT90  = 2'd1,
    MODE_ROT180 = 2'd2,
    MODE_ROT270 = 2'd3
  } mode_t;

  // Saturated frame geometry as seen by the front and back parts.
  typedef struct packed {
    logic [SIZE_W-1:0] width;
    logic [SIZE_W-1:0] height;
    logic [CH_W-1:0]   channels;
    mode_t             mode;
  } cfg_t;

  function automatic logic [SIZE_W-1:0] sat_size(input logic [SIZE_W-1:0] v,
                                                 input int unsigned hi);
    logic [SIZE_W-1:0] r;
    r = v;
    if (v == '0) begin
      r = SIZE_W'(1);
    end else if (32'(v) > hi) begin
      r = SIZE_W'(hi);
    end
    return r;
  endfunction

  function automatic logic [CH_W-1:0] sat_chan(input logic [CH_W-1:0] v,
                                               input int unsigned hi);
    logic [CH_W-1:0] r;
    r = v;
    if (v == '0) begin
      r = CH_W'(1);
    end else if (32'(v) > hi) begin
      r = CH_W'(hi);
    end
    return r;
  endfunction

endpackage

@@ rtl/image_rotate_right_angle_core.sv @@
// Top level of the right-angle rotation address generator.
// Usage:
//   Samples enter on in_valid/in_ready/sample_in in raster order, channel
//   fastest, then column, then row. Each accepted item yields exactly one
//   result on out_valid/out_ready carrying the sample, its index in the
//   rotated buffer, the frame-end flag and the rotated width and height.
//   Geometry and rotation are set through cfg_write/cfg_index/cfg_data,
//   one register per cycle, by the user only while no item is in flight;
//   the block itself does not enforce this. An item waits in a queue slot,
//   then passes the pixel-offset stage, the pixel multiply stage and the
//   channel multiply into the output register. Throughput: one item per
//   cycle while the receiver keeps up; the 13x13-bit pixel multiply and
//   the channel multiply each take a pipeline stage of their own.
//   When the receiver stalls the pipeline holds and the four-entry queue
//   fills; in_ready drops only once the queue is full.
//   Reset clears the raster counters, empties the queue and pipeline and
//   loads width 1, height 1, three channels and no rotation.
module image_rotate_right_angle_core #(
  parameter int MAX_WIDTH    = irr_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT   = irr_pkg::DEF_MAX_HEIGHT,
  parameter int MAX_CHANNELS = irr_pkg::DEF_MAX_CHANNELS
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_write,
  input  logic [irr_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [irr_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [irr_pkg::SAMPLE_W-1:0]    sample_in,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [irr_pkg::SAMPLE_W-1:0]    sample_out,
  output logic [irr_pkg::INDEX_W-1:0]     dest_index,
  output logic                            frame_last,
  output logic [irr_pkg::SIZE_W-1:0]      out_width,
  output logic [irr_pkg::SIZE_W-1:0]      out_height
);
  import irr_pkg::*;

  localparam int XW      = $clog2(MAX_WIDTH);
  localparam int YW      = $clog2(MAX_HEIGHT);
  localparam int CHW     = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int ENTRY_W = SAMPLE_W + 1 + CHW + YW + XW;

  logic [SIZE_W-1:0] image_width, image_height;
  logic [CH_W-1:0]   channel_count;
  mode_t             rotation_mode;
  cfg_t              cfg;

  logic               q_push, q_full, q_pop, q_not_empty;
  logic [ENTRY_W-1:0] q_in, q_head;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width   <= RESET_WIDTH;
      image_height  <= RESET_HEIGHT;
      channel_count <= RESET_CHANNELS;
      rotation_mode <= MODE_NONE;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_IMAGE_WIDTH:   image_width   <= cfg_data;
        REG_IMAGE_HEIGHT:  image_height  <= cfg_data;
        REG_CHANNEL_COUNT: channel_count <= cfg_data[CH_W-1:0];
        REG_ROTATION_MODE: rotation_mode <= mode_t'(cfg_data[MODE_W-1:0]);
        default: ;
      endcase
    end
  end

  // Bring sizes into their supported ranges before use.
  always_comb begin
    cfg.width    = sat_size(image_width, MAX_WIDTH);
    cfg.height   = sat_size(image_height, MAX_HEIGHT);
    cfg.channels = sat_chan(channel_count, MAX_CHANNELS);
    cfg.mode     = rotation_mode;
  end

  irr_front #(
    .MAX_WIDTH    (MAX_WIDTH),
    .MAX_HEIGHT   (MAX_HEIGHT),
    .MAX_CHANNELS (MAX_CHANNELS),
    .ENTRY_W      (ENTRY_W)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .sample_in (sample_in),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_data    (q_in)
  );

  irr_queue #(
    .DATA_W (ENTRY_W),
    .DEPTH  (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .head      (q_head)
  );

  irr_back #(
    .MAX_WIDTH    (MAX_WIDTH),
    .MAX_HEIGHT   (MAX_HEIGHT),
    .MAX_CHANNELS (MAX_CHANNELS),
    .ENTRY_W      (ENTRY_W)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .q_valid    (q_not_empty),
    .q_head     (q_head),
    .q_pop      (q_pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .sample_out (sample_out),
    .dest_index (dest_index),
    .frame_last (frame_last),
    .out_width  (out_width),
    .out_height (out_height)
  );

endmodule

@@ rtl/irr_front.sv @@
// Front part: raster counters, coordinate clamping and frame-end detection.
`include "assert_macros.svh"

module irr_front #(
  parameter int MAX_WIDTH    = irr_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT   = irr_pkg::DEF_MAX_HEIGHT,
  parameter int MAX_CHANNELS = irr_pkg::DEF_MAX_CHANNELS,
  parameter int ENTRY_W      = 40
) (
  input  logic                           clk,
  input  logic                           rst,
  input  irr_pkg::cfg_t                  cfg,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [irr_pkg::SAMPLE_W-1:0]   sample_in,
  input  logic                           q_full,
  output logic                           q_push,
  output logic [ENTRY_W-1:0]             q_data
);
  import irr_pkg::*;

  localparam int XW  = $clog2(MAX_WIDTH);
  localparam int YW  = $clog2(MAX_HEIGHT);
  localparam int CHW = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int XCW = (XW > SIZE_W) ? XW : SIZE_W;
  localparam int YCW = (YW > SIZE_W) ? YW : SIZE_W;
  localparam int CCW = (CHW > CH_W) ? CHW : CH_W;

  logic [XW-1:0]  column_count, column_count_next;
  logic [YW-1:0]  row_count, row_count_next;
  logic [CHW-1:0] channel_index, channel_index_next;

  logic [XCW-1:0] x_wide, w_wide, xe_wide;
  logic [YCW-1:0] y_wide, h_wide, ye_wide;
  logic [CCW-1:0] c_wide, nc_wide, ce_wide;
  logic           end_chan, end_col, end_row, last;

  assign in_ready = !q_full;
  assign q_push   = in_valid && !q_full;

  always_comb begin
    x_wide  = XCW'(column_count);
    w_wide  = XCW'(cfg.width);
    y_wide  = YCW'(row_count);
    h_wide  = YCW'(cfg.height);
    c_wide  = CCW'(channel_index);
    nc_wide = CCW'(cfg.channels);
    // Clamp counters left beyond a size that shrank mid-frame.
    xe_wide = (x_wide >= w_wide) ? w_wide - XCW'(1) : x_wide;
    ye_wide = (y_wide >= h_wide) ? h_wide - YCW'(1) : y_wide;
    ce_wide = (c_wide >= nc_wide) ? nc_wide - CCW'(1) : c_wide;

    end_chan = (ce_wide == nc_wide - CCW'(1));
    end_col  = (xe_wide == w_wide - XCW'(1));
    end_row  = (ye_wide == h_wide - YCW'(1));
    last     = end_chan && end_col && end_row;

    channel_index_next = CHW'(ce_wide + CCW'(1));
    column_count_next  = xe_wide[XW-1:0];
    row_count_next     = ye_wide[YW-1:0];
    if (end_chan) begin
      channel_index_next = '0;
      if (end_col) begin
        column_count_next = '0;
        row_count_next    = end_row ? '0 : YW'(ye_wide + YCW'(1));
      end else begin
        column_count_next = XW'(xe_wide + XCW'(1));
      end
    end

    q_data = {sample_in, last, ce_wide[CHW-1:0], ye_wide[YW-1:0], xe_wide[XW-1:0]};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count  <= '0;
      row_count     <= '0;
      channel_index <= '0;
    end else if (q_push) begin
      column_count  <= column_count_next;
      row_count     <= row_count_next;
      channel_index <= channel_index_next;
    end
  end

  `IRR_ASSERT(a_wrap_after_last, clk, rst,
    (q_push && last) |=> (column_count == '0 && row_count == '0 && channel_index == '0),
    "counters did not return to zero after the last sample")

endmodule

@@ rtl/irr_queue.sv @@
// Short item queue between the front and back parts.
`include "assert_macros.svh"

module irr_queue #(
  parameter int DATA_W = 40,
  parameter int DEPTH  = irr_pkg::QUEUE_DEPTH
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  logic [DATA_W-1:0] push_data,
  output logic              full,
  input  logic              pop,
  output logic              not_empty,
  output logic [DATA_W-1:0] head
);
  import irr_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [DATA_W-1:0] slots [DEPTH];
  logic [PTR_W-1:0]  wr_ptr, rd_ptr;
  logic [CNT_W-1:0]  count;

  assign full      = (count == CNT_W'(DEPTH));
  assign not_empty = (count != '0);
  assign head      = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  `IRR_ASSERT(a_count_bound, clk, rst, count <= CNT_W'(DEPTH),
    "queue fill count beyond depth")
  `IRR_ASSERT(a_count_step, clk, rst,
    (push && !pop) |=> (count == $past(count) + CNT_W'(1)),
    "queue fill count did not advance on a lone push")

endmodule

@@ rtl/irr_back.sv @@
// Back part: three-stage destination index pipeline whose last stage is the output register.
`include "assert_macros.svh"

module irr_back #(
  parameter int MAX_WIDTH    = irr_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT   = irr_pkg::DEF_MAX_HEIGHT,
  parameter int MAX_CHANNELS = irr_pkg::DEF_MAX_CHANNELS,
  parameter int ENTRY_W      = 40
) (
  input  logic                          clk,
  input  logic                          rst,
  input  irr_pkg::cfg_t                 cfg,
  input  logic                          q_valid,
  input  logic [ENTRY_W-1:0]            q_head,
  output logic                          q_pop,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [irr_pkg::SAMPLE_W-1:0]  sample_out,
  output logic [irr_pkg::INDEX_W-1:0]   dest_index,
  output logic                          frame_last,
  output logic [irr_pkg::SIZE_W-1:0]    out_width,
  output logic [irr_pkg::SIZE_W-1:0]    out_height
);
  import irr_pkg::*;

  localparam int XW  = $clog2(MAX_WIDTH);
  localparam int YW  = $clog2(MAX_HEIGHT);
  localparam int CHW = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int XYW = (XW > YW) ? XW : YW;
  localparam int CW  = (XYW > SIZE_W) ? XYW : SIZE_W;
  localparam int PW  = CW + SIZE_W;

  // Unpack the queue head.
  logic [XW-1:0]       hx;
  logic [YW-1:0]       hy;
  logic [CHW-1:0]      hc;
  logic                hlast;
  logic [SAMPLE_W-1:0] hsample;

  assign {hsample, hlast, hc, hy, hx} = q_head;

  logic [SIZE_W-1:0] ow, oh;
  logic [CW-1:0]     xw, yw, oww, ohw, a_in, b_in;

  // Stage registers.
  logic                v1, v2, v3;
  logic [CW-1:0]       a1, b1;
  logic [CHW-1:0]      c1, c2;
  logic [SAMPLE_W-1:0] s1, s2;
  logic                l1, l2;
  logic [INDEX_W-1:0]  pix2;
  logic [PW-1:0]       pix_full;
  logic [INDEX_W+CH_W-1:0] idx_full;
  logic                adv1, adv2, adv3;

  assign ow = cfg.mode[0] ? cfg.height : cfg.width;
  assign oh = cfg.mode[0] ? cfg.width : cfg.height;

  always_comb begin
    xw  = CW'(hx);
    yw  = CW'(hy);
    oww = CW'(ow);
    ohw = CW'(oh);
    // Destination pixel is a * ow + b for every mode.
    case (cfg.mode)
      MODE_ROT90: begin
        a_in = xw;
        b_in = oww - yw - CW'(1);
      end
      MODE_ROT180: begin
        a_in = ohw - yw - CW'(1);
        b_in = oww - xw - CW'(1);
      end
      MODE_ROT270: begin
        a_in = ohw - xw - CW'(1);
        b_in = yw;
      end
      default: begin
        a_in = yw;
        b_in = xw;
      end
    endcase
  end

  // Each stage advances when the one after it has room.
  assign adv3  = !v3 || out_ready;
  assign adv2  = !v2 || adv3;
  assign adv1  = !v1 || adv2;
  assign q_pop = q_valid && adv1;

  assign pix_full = a1 * PW'(ow) + PW'(b1);
  assign idx_full = (INDEX_W + CH_W)'(pix2) * (INDEX_W + CH_W)'(cfg.channels)
                  + (INDEX_W + CH_W)'(c2);

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (adv1) v1 <= q_valid;
      if (adv2) v2 <= v1;
      if (adv3) v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (adv1) begin
      a1 <= a_in;
      b1 <= b_in;
      c1 <= hc;
      s1 <= hsample;
      l1 <= hlast;
    end
    if (adv2) begin
      pix2 <= pix_full[INDEX_W-1:0];
      c2   <= c1;
      s2   <= s1;
      l2   <= l1;
    end
    if (adv3) begin
      dest_index <= idx_full[INDEX_W-1:0];
      sample_out <= s2;
      frame_last <= l2;
    end
  end

  assign out_valid  = v3;
  assign out_width  = ow;
  assign out_height = oh;

  `IRR_ASSERT(a_stage2_source, clk, rst, $rose(v2) |-> $past(v1),
    "index stage filled without a pixel stage item")
  `IRR_ASSERT(a_stage3_source, clk, rst, $rose(v3) |-> $past(v2),
    "output stage filled without an index stage item")

endmodule

@@ tb/sv/tb_image_rotate_right_angle_core.sv @@
// Testbench for the right-angle rotation address generator: directed table, random phases.
`timescale 1ns / 100ps

module tb_image_rotate_right_angle_core;
  import irr_pkg::*;

  typedef struct packed {
    logic [SAMPLE_W-1:0] sample;
    logic [INDEX_W-1:0]  index;
    logic                last;
    logic [SIZE_W-1:0]   width;
    logic [SIZE_W-1:0]   height;
  } rot_result_t;

  typedef struct packed {
    logic                  reconfig;
    logic [CFG_DATA_W-1:0] width_data;
    logic [CFG_DATA_W-1:0] height_data;
    logic [CFG_DATA_W-1:0] chan_data;
    logic [CFG_DATA_W-1:0] mode_data;
    logic [SAMPLE_W-1:0]   sample;
    logic                  typed;
    rot_result_t           want;
  } dir_row_t;

  localparam int DIR_ROWS    = 24;
  localparam int RAND_ITEMS  = 1800;
  localparam int MAX_PRINTS  = 10;
  localparam rot_result_t NO_RESULT = '0;

  // Typed rows: state after reset, the largest frame in 180, and saturated sizes with
  // a column counter left beyond the new width. Others are left to the predictor.
  localparam dir_row_t DIRECTED [DIR_ROWS] = '{
    '{1'b0, 13'd0, 13'd0, 13'd0, 13'd0, 8'h00, 1'b1,
      '{8'h00, 26'd0, 1'b0, 13'd1, 13'd1}},
    '{1'b0, 13'd0, 13'd0, 13'd0, 13'd0, 8'hFF, 1'b1,
      '{8'hFF, 26'd1, 1'b0, 13'd1, 13'd1}},
    '{1'b0, 13'd0, 13'd0, 13'd0, 13'd0, 8'h5A, 1'b1,
      '{8'h5A, 26'd2, 1'b1, 13'd1, 13'd1}},
    '{1'b1, 13'd4096, 13'd4096, 13'd4, 13'(MODE_ROT180), 8'hFF, 1'b1,
      '{8'hFF, 26'd67108860, 1'b0, 13'd4096, 13'd4096}},
    '{1'b0, 13'd0, 13'd0, 13'd0, 13'd0, 8'h00, 1'b1,
      '{8'h00, 26'd67108861, 1'b0, 13'd4096, 13'd4096}},
    '{1'b0, 13'd0, 13'd0, 13'd0, 13'd0, 8'hA5, 1'b1,
      '{8'hA5, 26'd67108862, 1'b0, 13'd4096, 13'd4096}},
    '{1'b0, 13'd0, 13'd0, 13'd0, 13'd0, 8'h3C, 1'b1,
      '{8'h3C, 26'd67108863, 1'b0, 13'd4096, 13'd4096}},
    '{1'b1, 13'd0, 13'd8191, 13'd0, 13'(MODE_ROT90), 8'h81, 1'b1,
      '{8'h81, 26'd4095, 1'b0, 13'd4096, 13'd1}},
    '{1'b0, 13'd0, 13'd0, 13'd0, 13'd0, 8'h7E, 1'b0, NO_RESULT},
    '{1'b1, 13'd3, 13'd2, 13'd7, 13'(MODE_ROT270), 8'h01, 1'b0, NO_RESULT},
    '{1'b0, 13'd0, 13'd0, 13'd0, 13'd0, 8'h02, 1'b0, NO_RESULT},
    '{1'b0, 13'd0, 13'd0, 13'd0, 13'd0, 8'h04, 1'b0, NO_RESULT},
    '{1'b0, 13'd0, 13'd0, 13'd0, 13'd0, 8'h08, 1'b0, NO_RESULT},
    '{1'b1, 13'd2, 13'd3, 13'd1, 13'(MODE_NONE), 8'h10, 1'b0, NO_RESULT},
    '{1'b0, 13'd0, 13'd0, 13'd0, 13'd0, 8'h20, 1'b0, NO_RESULT},
    '{1'b0, 13'd0, 13'd0, 13'd0, 13'd0, 8'h40, 1'b0, NO_RESULT},
    '{1'b1, 13'd3, 13'd2, 13'd2, 13'(MODE_ROT90), 8'h80, 1'b0, NO_RESULT},
    '{1'b0, 13'd0, 13'd0, 13'd0, 13'd0, 8'hFE, 1'b0, NO_RESULT},
    '{1'b0, 13'd0, 13'd0, 13'd0, 13'd0, 8'hFD, 1'b0, NO_RESULT},
    '{1'b1, 13'd4097, 13'd1, 13'd5, 13'(MODE_ROT180), 8'hFB, 1'b0, NO_RESULT},
    '{1'b0, 13'd0, 13'd0, 13'd0, 13'd0, 8'hF7, 1'b0, NO_RESULT},
    '{1'b1, 13'd1, 13'd1, 13'h1FFE, 13'h1FFC, 8'hEF, 1'b0, NO_RESULT},
    '{1'b0, 13'd0, 13'd0, 13'd0, 13'd0, 8'hDF, 1'b0, NO_RESULT},
    '{1'b0, 13'd0, 13'd0, 13'd0, 13'd0, 8'hBF, 1'b0, NO_RESULT}
  };

  logic                   clk;
  logic                   rst;
  logic                   cfg_write;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;
  logic                   in_valid;
  logic                   in_ready;
  logic [SAMPLE_W-1:0]    sample_in;
  logic                   out_valid;
  logic                   out_ready;
  logic [SAMPLE_W-1:0]    sample_out;
  logic [INDEX_W-1:0]     dest_index;
  logic                   frame_last;
  logic [SIZE_W-1:0]      out_width;
  logic [SIZE_W-1:0]      out_height;

  // Register shadows and raster position of the predictor
  logic [SIZE_W-1:0] geo_width;
  logic [SIZE_W-1:0] geo_height;
  logic [CH_W-1:0]   geo_chans;
  mode_t             geo_mode;
  int unsigned       col_pos;
  int unsigned       row_pos;
  int unsigned       chan_pos;

  rot_result_t pending_results[$];
  int unsigned fault_count;
  int unsigned print_count;
  int unsigned items_sent;
  int unsigned results_seen;
  int unsigned frames_seen;
  int unsigned phase_count;
  int unsigned burst_left;

  image_rotate_right_angle_core u_dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .sample_in  (sample_in),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .sample_out (sample_out),
    .dest_index (dest_index),
    .frame_last (frame_last),
    .out_width  (out_width),
    .out_height (out_height)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("tb: failure");
    $finish;
  end

  // Work out the result of one sample and advance the raster position.
  function automatic rot_result_t predict_rotation(input logic [SAMPLE_W-1:0] v);
    longint unsigned w, h, nc, x, y, c, ow, oh, pix;
    rot_result_t r;
    w  = (geo_width == '0) ? 1 : (geo_width > DEF_MAX_WIDTH) ? DEF_MAX_WIDTH : geo_width;
    h  = (geo_height == '0) ? 1 : (geo_height > DEF_MAX_HEIGHT) ? DEF_MAX_HEIGHT : geo_height;
    nc = (geo_chans == '0) ? 1 : (geo_chans > DEF_MAX_CHANNELS) ? DEF_MAX_CHANNELS : geo_chans;
    x = col_pos;
    y = row_pos;
    c = chan_pos;
    // pull a counter left beyond a shrunken size back to the last position
    if (x >= w) x = w - 1;
    if (y >= h) y = h - 1;
    if (c >= nc) c = nc - 1;
    if (geo_mode[0]) begin
      ow = h;
      oh = w;
    end else begin
      ow = w;
      oh = h;
    end
    case (geo_mode)
      MODE_ROT90:  pix = x * ow + (ow - y - 1);
      MODE_ROT180: pix = (oh - y - 1) * ow + (ow - x - 1);
      MODE_ROT270: pix = (oh - x - 1) * ow + y;
      default:     pix = y * w + x;
    endcase
    r.sample = v;
    r.index  = INDEX_W'(pix * nc + c);
    r.last   = (c == nc - 1) && (x == w - 1) && (y == h - 1);
    r.width  = SIZE_W'(ow);
    r.height = SIZE_W'(oh);
    c++;
    if (c >= nc) begin
      c = 0;
      x++;
      if (x >= w) begin
        x = 0;
        y++;
        if (y >= h) y = 0;
      end
    end
    col_pos  = int'(x);
    row_pos  = int'(y);
    chan_pos = int'(c);
    return r;
  endfunction

  // Offer one sample, hold it until accepted, then queue its result.
  task automatic send_sample(input logic [SAMPLE_W-1:0] v, input bit typed,
                             input rot_result_t want);
    rot_result_t got;
    int unsigned gap;
    @(negedge clk);
    in_valid  <= 1'b1;
    sample_in <= v;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    got = predict_rotation(v);
    pending_results.push_back(typed ? want : got);
    items_sent++;
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        @(negedge clk);
        in_valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
  endtask

  // Drain the block, then write the registers selected by the mask.
  task automatic set_geometry(input logic [CFG_DATA_W-1:0] w, input logic [CFG_DATA_W-1:0] h,
                              input logic [CFG_DATA_W-1:0] nc,
                              input logic [CFG_DATA_W-1:0] mode, input logic [3:0] mask);
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    for (int i = 0; i < 4; i++) begin
      if (mask[i]) begin
        @(negedge clk);
        cfg_write <= 1'b1;
        case (reg_index_t'(i))
          REG_IMAGE_WIDTH: begin
            cfg_index <= REG_IMAGE_WIDTH;
            cfg_data  <= w;
            geo_width = w;
          end
          REG_IMAGE_HEIGHT: begin
            cfg_index <= REG_IMAGE_HEIGHT;
            cfg_data  <= h;
            geo_height = h;
          end
          REG_CHANNEL_COUNT: begin
            cfg_index <= REG_CHANNEL_COUNT;
            cfg_data  <= nc;
            geo_chans = nc[CH_W-1:0];
          end
          default: begin
            cfg_index <= REG_ROTATION_MODE;
            cfg_data  <= mode;
            geo_mode = mode_t'(mode[MODE_W-1:0]);
          end
        endcase
      end
    end
    @(negedge clk);
    cfg_write <= 1'b0;
    phase_count++;
  endtask

  // Receiver: stretches of steady, random, periodic and long stalls
  initial begin
    int unsigned stretch;
    int unsigned style;
    out_ready = 1'b0;
    forever begin
      stretch = $urandom_range(8, 64);
      style   = $urandom_range(0, 3);
      for (int k = 0; k < stretch; k++) begin
        @(negedge clk);
        case (style)
          0:       out_ready <= 1'b1;
          1:       out_ready <= 1'($urandom_range(0, 1));
          2:       out_ready <= (k % 4 != 3);
          default: out_ready <= (k % 16 >= 10);
        endcase
      end
    end
  end

  // Compare every accepted result with the oldest expectation
  always @(posedge clk) begin
    rot_result_t exp_r;
    if (!rst && out_valid && out_ready) begin
      results_seen++;
      if (frame_last) frames_seen++;
      if (pending_results.size() == 0) begin
        fault_count++;
        if (print_count < MAX_PRINTS) begin
          print_count++;
          $display("unexpected item: sample %h index %0d last %b size %0dx%0d",
                   sample_out, dest_index, frame_last, out_width, out_height);
        end
      end else begin
        exp_r = pending_results.pop_front();
        if (sample_out !== exp_r.sample || dest_index !== exp_r.index ||
            frame_last !== exp_r.last || out_width !== exp_r.width ||
            out_height !== exp_r.height) begin
          fault_count++;
          if (print_count < MAX_PRINTS) begin
            print_count++;
            $display("mismatch at result %0d:", results_seen);
            $display("  sample exp %h got %h, index exp %0d got %0d, last exp %b got %b",
                     exp_r.sample, sample_out, exp_r.index, dest_index,
                     exp_r.last, frame_last);
            $display("  width exp %0d got %0d, height exp %0d got %0d",
                     exp_r.width, out_width, exp_r.height, out_height);
          end
        end
      end
    end
  end

  initial begin
    dir_row_t row;
    int unsigned kind;
    int unsigned count;
    int unsigned waited;
    logic [CFG_DATA_W-1:0] w, h, nc, mode;
    rst        = 1'b1;
    cfg_write  = 1'b0;
    cfg_index  = REG_IMAGE_WIDTH;
    cfg_data   = '0;
    in_valid   = 1'b0;
    sample_in  = '0;
    geo_width  = RESET_WIDTH;
    geo_height = RESET_HEIGHT;
    geo_chans  = RESET_CHANNELS;
    geo_mode   = MODE_NONE;
    col_pos    = 0;
    row_pos    = 0;
    chan_pos   = 0;
    fault_count  = 0;
    print_count  = 0;
    items_sent   = 0;
    results_seen = 0;
    frames_seen  = 0;
    phase_count  = 0;
    burst_left   = $urandom_range(1, 40);
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    for (int i = 0; i < DIR_ROWS; i++) begin
      row = DIRECTED[i];
      if (row.reconfig)
        set_geometry(row.width_data, row.height_data, row.chan_data, row.mode_data, 4'b1111);
      send_sample(row.sample, row.typed, row.want);
    end

    while (items_sent < DIR_ROWS + RAND_ITEMS) begin
      kind = $urandom_range(0, 9);
      mode = 13'($urandom_range(0, 3));
      if (kind <= 6) begin
        w  = 13'($urandom_range(1, 6));
        h  = 13'($urandom_range(1, 6));
        nc = 13'($urandom_range(1, 4));
      end else if (kind == 7) begin
        // sizes outside the legal range get saturated
        w  = ($urandom_range(0, 1) == 0) ? 13'd0 : 13'($urandom_range(4097, 8191));
        h  = ($urandom_range(0, 1) == 0) ? 13'd0 : 13'($urandom_range(4097, 8191));
        nc = ($urandom_range(0, 3) == 0) ? 13'd0 : 13'($urandom_range(5, 7));
      end else if (kind == 8) begin
        w  = ($urandom_range(0, 1) == 0) ? 13'd4096 : 13'($urandom_range(1, 4096));
        h  = ($urandom_range(0, 1) == 0) ? 13'd4096 : 13'($urandom_range(1, 4096));
        nc = 13'($urandom_range(1, 4));
      end else begin
        w    = 13'($urandom);
        h    = 13'($urandom);
        nc   = 13'($urandom);
        mode = 13'($urandom);
      end
      // leave a register unwritten now and then so old values carry over
      set_geometry(w, h, nc, mode, ($urandom_range(0, 2) == 0) ? 4'($urandom) : 4'b1111);
      count = (kind <= 6) ? $urandom_range(1, 120) : $urandom_range(1, 60);
      for (int n = 0; n < count; n++)
        send_sample(8'($urandom), 1'b0, NO_RESULT);
    end

    @(negedge clk);
    in_valid <= 1'b0;
    waited = 0;
    while (pending_results.size() != 0 && waited < 20000) begin
      @(posedge clk);
      waited++;
    end
    repeat (8) @(posedge clk);
    if (pending_results.size() != 0) begin
      fault_count++;
      $display("%0d expected items never arrived", pending_results.size());
    end
    $display("covered %0d samples in %0d geometry phases, %0d results, %0d frame ends",
             items_sent, phase_count, results_seen, frames_seen);
    if (fault_count == 0) begin
      $display("tb: success");
    end else begin
      $display("%0d failures", fault_count);
      $display("tb: failure");
    end
    $finish;
  end

endmodule
